// File: rtl/core/lcfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcfp_pkg
// Shared types, constants and helper functions of the pointwise LSTM cell
// datapath: Q4.11 saturation and the piecewise-linear sigmoid table.
// ----------------------------------------------------------------------------
package lcfp_pkg;

   localparam int NUM_GATES = 4;
   localparam int GATE_INPUT = 0;
   localparam int GATE_CAND = 1;
   localparam int GATE_FORGET = 2;
   localparam int GATE_OUTPUT = 3;

   localparam int FRAC_BITS = 11;
   localparam logic signed [12:0] Q_ONE = 13'sd2048;
   localparam logic signed [31:0] ROUND_HALF = 32'sd1024;
   localparam logic [63:0] EXP_STEP_Q32 = 64'd4034748382;

   typedef logic [11:0] sig_table_type [0:256];

   function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
      logic signed [15:0] r;
      if (v > 32'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -32'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   function automatic logic [11:0] sig_pos(input int m);
      logic [63:0] e;
      logic [63:0] den;
      logic [63:0] num;
      logic [63:0] rem;
      logic [63:0] q;
      e = 64'h1_0000_0000;
      for (int n = 0; n < m; n++) begin
         e = (e * EXP_STEP_Q32 + 64'h8000_0000) >> 32;
      end
      den = 64'h1_0000_0000 + e;
      num = (64'd2048 << 32) + (den >> 1);
      rem = '0;
      q = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[62:0], num[i]};
         if (rem >= den) begin
            rem = rem - den;
            q[i] = 1'b1;
         end
      end
      return q[11:0];
   endfunction

   function automatic sig_table_type build_sig_table();
      sig_table_type t;
      for (int k = 0; k <= 256; k++) begin
         if (k >= 128) begin
            t[k] = sig_pos(k - 128);
         end else begin
            t[k] = 12'd2048 - sig_pos(128 - k);
         end
      end
      return t;
   endfunction

   localparam sig_table_type SIG_TABLE = build_sig_table();

endpackage

// File: rtl/core/lcfp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcfp_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lcfp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/lcfp_sigmoid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcfp_sigmoid
// Two-stage piecewise-linear sigmoid, Q4.11 in and unsigned Q1.11 out: table lookup, then interpolation.
// ----------------------------------------------------------------------------
module lcfp_sigmoid (
   input  logic               clock,
   input  logic signed [15:0] x,
   output logic [11:0]        y
);
   import lcfp_pkg::*;

   logic signed [15:0] clamped;
   logic [14:0]        u;
   logic [7:0]         seg;
   logic [8:0]         seg_next;
   logic [11:0]        base_in;
   logic [11:0]        base_ff;
   logic signed [12:0] slope_in;
   logic signed [12:0] slope_ff;
   logic [6:0]         off_ff;
   logic signed [20:0] prod;
   logic signed [20:0] interp;
   logic [11:0]        y_ff;

   always_comb begin
      if (x < -16'sd16384) begin
         clamped = -16'sd16384;
      end else if (x > 16'sd16383) begin
         clamped = 16'sd16383;
      end else begin
         clamped = x;
      end
      u = 15'(clamped + 16'sd16384);
      seg = u[14:7];
      seg_next = {1'b0, seg} + 9'd1;
      base_in = SIG_TABLE[seg];
      slope_in = signed'({1'b0, SIG_TABLE[seg_next]}) - signed'({1'b0, SIG_TABLE[seg]});
   end

   always_ff @(posedge clock) begin
      base_ff <= base_in;
      slope_ff <= slope_in;
      off_ff <= u[6:0];
   end

   always_comb begin
      prod = 21'(slope_ff) * signed'({14'd0, off_ff});
      interp = (prod + 21'sd64) >>> 7;
   end

   always_ff @(posedge clock) begin
      y_ff <= 12'(signed'({9'd0, base_ff}) + interp);
   end

   assign y = y_ff;

endmodule

// File: rtl/core/lstm_cell_forward_pointwise_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lstm_cell_forward_pointwise_top
// Pointwise LSTM cell step in saturating Q4.11 with a per-unit bias table.
//
// Channel   Ports                   Handshake
// request   start, busy, req_*      beat taken when start is high, busy low
// response  rsp_valid, rsp_*        one-cycle strobe, no back pressure
//
// One beat is accepted every cycle; busy is never raised.
// Results appear in the order of their request beats. The gate, sigmoid and
// product pipeline has ten register stages. Reset clears only the valid
// pipeline; bias entries are undefined until loaded.
// ----------------------------------------------------------------------------
module lstm_cell_forward_pointwise_top #(
   parameter int HIDDEN_UNITS = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_func,
   input  logic [7:0]         req_unit_index,
   input  logic signed [15:0] req_input_gate_xproj,
   input  logic signed [15:0] req_cand_gate_xproj,
   input  logic signed [15:0] req_forget_gate_xproj,
   input  logic signed [15:0] req_output_gate_xproj,
   input  logic signed [15:0] req_input_gate_hproj,
   input  logic signed [15:0] req_cand_gate_hproj,
   input  logic signed [15:0] req_forget_gate_hproj,
   input  logic signed [15:0] req_output_gate_hproj,
   input  logic signed [15:0] req_cell_prev,
   output logic               rsp_valid,
   output logic signed [15:0] rsp_cell_new,
   output logic signed [15:0] rsp_hidden_new
);
   import lcfp_pkg::*;

   localparam int AW = (HIDDEN_UNITS > 1) ? $clog2(HIDDEN_UNITS) : 1;

   logic               accept;
   logic               unit_ok;
   logic [AW-1:0]      addr;
   logic signed [15:0] xp [NUM_GATES];
   logic signed [15:0] hp [NUM_GATES];
   logic [15:0]        bias [NUM_GATES];

   logic [9:0]         valid_pipe_ff;
   logic [9:0]         valid_pipe_in;
   logic [9:0]         func_pipe_ff;

   logic signed [15:0] s1_x_ff [NUM_GATES];
   logic signed [15:0] s1_h_ff [NUM_GATES];
   logic               s1_bias_ok_ff;
   logic signed [15:0] pre_in [NUM_GATES];
   logic signed [15:0] s2_pre_ff [NUM_GATES];
   logic [11:0]        sig [NUM_GATES];
   logic signed [15:0] cp1_ff, cp2_ff, cp3_ff, cp4_ff;

   logic signed [12:0] gg;
   logic signed [31:0] pf_in, pi_in;
   logic signed [31:0] s5_pf_ff, s5_pi_ff;
   logic [11:0]        og5_ff, og6_ff, og7_ff, og8_ff;
   logic signed [15:0] c_in;
   logic signed [15:0] c6_ff, c7_ff, c8_ff, c9_ff;
   logic signed [15:0] tanh_arg;
   logic [11:0]        sig_c;
   logic signed [12:0] tc;
   logic signed [31:0] ph_in;
   logic signed [31:0] s9_ph_ff;
   logic signed [15:0] h_in;
   logic signed [15:0] rsp_cell_ff, rsp_hidden_ff;

   assign busy = 1'b0;
   assign accept = start && !busy;
   assign unit_ok = 32'(req_unit_index) < HIDDEN_UNITS;
   assign addr = AW'(req_unit_index);

   assign xp[GATE_INPUT] = req_input_gate_xproj;
   assign xp[GATE_CAND] = req_cand_gate_xproj;
   assign xp[GATE_FORGET] = req_forget_gate_xproj;
   assign xp[GATE_OUTPUT] = req_output_gate_xproj;
   assign hp[GATE_INPUT] = req_input_gate_hproj;
   assign hp[GATE_CAND] = req_cand_gate_hproj;
   assign hp[GATE_FORGET] = req_forget_gate_hproj;
   assign hp[GATE_OUTPUT] = req_output_gate_hproj;

   for (genvar g = 0; g < NUM_GATES; g++) begin : g_gate
      lcfp_ram #(
         .WIDTH(16),
         .DEPTH(HIDDEN_UNITS)
      ) u_bias (
         .clock  (clock),
         .wr_en  (accept && !req_func && unit_ok),
         .wr_addr(addr),
         .wr_data(xp[g]),
         .rd_addr(addr),
         .rd_data(bias[g])
      );

      always_comb begin
         logic signed [31:0] sum;
         sum = 32'(s1_x_ff[g]) + 32'(s1_h_ff[g])
             + (s1_bias_ok_ff ? 32'(signed'(bias[g])) : 32'sd0);
         if (g == GATE_CAND) begin
            pre_in[g] = sat16(32'(sat16(sum)) * 32'sd2);
         end else begin
            pre_in[g] = sat16(sum);
         end
      end

      lcfp_sigmoid u_sig (
         .clock(clock),
         .x    (s2_pre_ff[g]),
         .y    (sig[g])
      );
   end

   assign valid_pipe_in = {valid_pipe_ff[8:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_pipe_ff <= '0;
      end else begin
         valid_pipe_ff <= valid_pipe_in;
      end
   end

   always_ff @(posedge clock) begin
      func_pipe_ff <= {func_pipe_ff[8:0], req_func};
      s1_x_ff <= xp;
      s1_h_ff <= hp;
      s1_bias_ok_ff <= req_func && unit_ok;
      s2_pre_ff <= pre_in;
      cp1_ff <= req_cell_prev;
      cp2_ff <= cp1_ff;
      cp3_ff <= cp2_ff;
      cp4_ff <= cp3_ff;
   end

   always_comb begin
      gg = signed'({1'b0, sig[GATE_CAND]}) * 13'sd2 - Q_ONE;
      pf_in = 32'(signed'({1'b0, sig[GATE_FORGET]})) * 32'(cp4_ff);
      pi_in = 32'(signed'({1'b0, sig[GATE_INPUT]})) * 32'(gg);
      c_in = sat16((s5_pf_ff + s5_pi_ff + ROUND_HALF) >>> FRAC_BITS);
      tanh_arg = sat16(32'(c6_ff) * 32'sd2);
      tc = signed'({1'b0, sig_c}) * 13'sd2 - Q_ONE;
      ph_in = 32'(signed'({1'b0, og8_ff})) * 32'(tc);
      h_in = sat16((s9_ph_ff + ROUND_HALF) >>> FRAC_BITS);
   end

   lcfp_sigmoid u_sig_cell (
      .clock(clock),
      .x    (tanh_arg),
      .y    (sig_c)
   );

   always_ff @(posedge clock) begin
      s5_pf_ff <= pf_in;
      s5_pi_ff <= pi_in;
      og5_ff <= sig[GATE_OUTPUT];
      og6_ff <= og5_ff;
      og7_ff <= og6_ff;
      og8_ff <= og7_ff;
      c6_ff <= c_in;
      c7_ff <= c6_ff;
      c8_ff <= c7_ff;
      c9_ff <= c8_ff;
      s9_ph_ff <= ph_in;
      rsp_cell_ff <= func_pipe_ff[8] ? c9_ff : 16'sd0;
      rsp_hidden_ff <= func_pipe_ff[8] ? h_in : 16'sd0;
   end

   assign rsp_valid = valid_pipe_ff[9];
   assign rsp_cell_new = rsp_cell_ff;
   assign rsp_hidden_new = rsp_hidden_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##10 rsp_valid)
      else $error("request beat did not produce a response beat");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 10))
      else $error("response beat without a request beat");

   a_load_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !func_pipe_ff[9] |-> rsp_cell_new == 16'sd0 && rsp_hidden_new == 16'sd0)
      else $error("bias load beat returned nonzero data");

endmodule

// File: verif/lstm_cell_forward_pointwise_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lstm_cell_forward_pointwise_top_tb
// Self-checking bench for the pointwise LSTM cell step. Bias loads and cell
// steps are streamed with random gaps; an in-bench Q4.11 model of the bias
// table, the piecewise-linear sigmoid and the cell update predicts every
// response, which is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module lstm_cell_forward_pointwise_top_tb;
   import lcfp_pkg::*;

   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_STEP = 1'b1;
   localparam int UNITS = 256;

   typedef struct {
      logic              func;
      logic [7:0]        unit;
      logic signed [15:0] xp [NUM_GATES];
      logic signed [15:0] hp [NUM_GATES];
      logic signed [15:0] cell_prev;
   } cell_beat_type;

   typedef struct {
      logic signed [15:0] cell_new;
      logic signed [15:0] hidden_new;
   } cell_result_type;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic req_func;
   logic [7:0] req_unit_index;
   logic signed [15:0] req_xp [NUM_GATES];
   logic signed [15:0] req_hp [NUM_GATES];
   logic signed [15:0] req_cell_prev;
   logic rsp_valid;
   logic signed [15:0] rsp_cell_new;
   logic signed [15:0] rsp_hidden_new;

   cell_result_type pending_cell_results[$];
   logic signed [15:0] bias_mirror [4 * UNITS];
   logic [UNITS-1:0] unit_loaded;
   int loaded_units[$];
   longint sig_points [0:256];
   bit quiet;
   bit failed;

   lstm_cell_forward_pointwise_top u_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_func(req_func),
      .req_unit_index(req_unit_index),
      .req_input_gate_xproj(req_xp[GATE_INPUT]),
      .req_cand_gate_xproj(req_xp[GATE_CAND]),
      .req_forget_gate_xproj(req_xp[GATE_FORGET]),
      .req_output_gate_xproj(req_xp[GATE_OUTPUT]),
      .req_input_gate_hproj(req_hp[GATE_INPUT]),
      .req_cand_gate_hproj(req_hp[GATE_CAND]),
      .req_forget_gate_hproj(req_hp[GATE_FORGET]),
      .req_output_gate_hproj(req_hp[GATE_OUTPUT]),
      .req_cell_prev(req_cell_prev),
      .rsp_valid(rsp_valid),
      .rsp_cell_new(rsp_cell_new),
      .rsp_hidden_new(rsp_hidden_new)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("[lstm_cell_forward_pointwise_top] ERROR");
      $finish;
   end

   function automatic longint clamp16(input longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic longint round_q11(input longint v, input int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint positive_sigmoid(input int m);
      longint unsigned e;
      longint unsigned den;
      e = 64'h1_0000_0000;
      for (int n = 0; n < m; n++) begin
         e = (e * 64'd4034748382 + 64'h8000_0000) >> 32;
      end
      den = 64'h1_0000_0000 + e;
      return longint'(((64'd2048 << 32) + den / 2) / den);
   endfunction

   function automatic longint sigmoid_q11(input longint v);
      longint u;
      longint a;
      longint b;
      if (v < -16384) v = -16384;
      if (v > 16383) v = 16383;
      u = v + 16384;
      a = sig_points[u >> 7];
      b = sig_points[(u >> 7) + 1];
      return a + round_q11((b - a) * (u & 127), 7);
   endfunction

   function automatic longint tanh_q11(input longint v);
      return 2 * sigmoid_q11(clamp16(2 * v)) - 2048;
   endfunction

   function automatic cell_result_type cell_step_predict(input cell_beat_type bt);
      cell_result_type r;
      longint pre [NUM_GATES];
      longint ig, gg, fg, og, c;
      r.cell_new = '0;
      r.hidden_new = '0;
      if (bt.func == FUNC_LOAD) begin
         for (int g = 0; g < NUM_GATES; g++) begin
            bias_mirror[4 * bt.unit + g] = bt.xp[g];
         end
         return r;
      end
      for (int g = 0; g < NUM_GATES; g++) begin
         pre[g] = clamp16(longint'(bt.xp[g]) + longint'(bt.hp[g])
                          + longint'(bias_mirror[4 * bt.unit + g]));
      end
      ig = sigmoid_q11(pre[GATE_INPUT]);
      gg = tanh_q11(pre[GATE_CAND]);
      fg = sigmoid_q11(pre[GATE_FORGET]);
      og = sigmoid_q11(pre[GATE_OUTPUT]);
      c = clamp16(round_q11(fg * longint'(bt.cell_prev) + ig * gg, 11));
      r.cell_new = c[15:0];
      r.hidden_new = 16'(clamp16(round_q11(og * tanh_q11(c), 11)));
      return r;
   endfunction

   always @(posedge clock) begin
      cell_beat_type bt;
      cell_result_type exp_r;
      if (!reset && start && !busy) begin
         bt.func = req_func;
         bt.unit = req_unit_index;
         bt.xp = req_xp;
         bt.hp = req_hp;
         bt.cell_prev = req_cell_prev;
         pending_cell_results.push_back(cell_step_predict(bt));
      end
      if (!reset && rsp_valid) begin
         if (pending_cell_results.size() == 0) begin
            $error("unexpected response beat");
            failed = 1'b1;
         end else begin
            exp_r = pending_cell_results.pop_front();
            if (rsp_cell_new !== exp_r.cell_new) begin
               $error("cell_new expected %0d actual %0d", exp_r.cell_new, rsp_cell_new);
               failed = 1'b1;
            end
            if (rsp_hidden_new !== exp_r.hidden_new) begin
               $error("hidden_new expected %0d actual %0d", exp_r.hidden_new,
                      rsp_hidden_new);
               failed = 1'b1;
            end
         end
      end
   end

   task automatic send_beat(input cell_beat_type bt);
      while (!quiet && $urandom_range(99) < 20) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_func <= bt.func;
      req_unit_index <= bt.unit;
      req_xp <= bt.xp;
      req_hp <= bt.hp;
      req_cell_prev <= bt.cell_prev;
      do @(posedge clock); while (busy);
      if (bt.func == FUNC_LOAD && !unit_loaded[bt.unit]) begin
         unit_loaded[bt.unit] = 1'b1;
         loaded_units.push_back(bt.unit);
      end
   endtask

   function automatic logic signed [15:0] pick_q11();
      case ($urandom_range(5))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2, 3: return 16'($urandom_range(8191) - 4096);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic cell_beat_type fill_beat(input logic func, input logic [7:0] unit,
                                               input logic signed [15:0] v);
      cell_beat_type bt;
      bt.func = func;
      bt.unit = unit;
      for (int g = 0; g < NUM_GATES; g++) begin
         bt.xp[g] = v;
         bt.hp[g] = v;
      end
      bt.cell_prev = v;
      return bt;
   endfunction

   task automatic test_bias_load_extremes();
      send_beat(fill_beat(FUNC_LOAD, 8'd0, 16'sh7fff));
      send_beat(fill_beat(FUNC_LOAD, 8'd255, 16'sh8000));
      send_beat(fill_beat(FUNC_LOAD, 8'd85, 16'sd0));
      send_beat(fill_beat(FUNC_LOAD, 8'd170, 16'sd2048));
   endtask

   task automatic test_gate_saturation();
      cell_beat_type bt;
      logic signed [15:0] vals [6] = '{16'sh7fff, 16'sh8000, 16'sd0, 16'sd2048,
                                        -16'sd2048, 16'sd100};
      foreach (vals[i]) begin
         send_beat(fill_beat(FUNC_STEP, 8'd0, vals[i]));
         send_beat(fill_beat(FUNC_STEP, 8'd255, vals[i]));
      end
      bt = fill_beat(FUNC_STEP, 8'd85, 16'sh7fff);
      bt.xp[GATE_FORGET] = 16'sh8000;
      bt.hp[GATE_FORGET] = 16'sh8000;
      send_beat(bt);
      bt = fill_beat(FUNC_STEP, 8'd170, 16'sh8000);
      bt.xp[GATE_CAND] = 16'sh7fff;
      bt.cell_prev = 16'sh7fff;
      send_beat(bt);
   endtask

   task automatic test_random_stream(input int count);
      cell_beat_type bt;
      for (int n = 0; n < count; n++) begin
         quiet = (n >= count / 3 && n < count / 2);
         bt.func = ($urandom_range(9) < 2) ? FUNC_LOAD : FUNC_STEP;
         bt.unit = (bt.func == FUNC_LOAD) ? 8'($urandom)
                   : 8'(loaded_units[$urandom_range(loaded_units.size() - 1)]);
         for (int g = 0; g < NUM_GATES; g++) begin
            bt.xp[g] = pick_q11();
            bt.hp[g] = pick_q11();
         end
         bt.cell_prev = pick_q11();
         send_beat(bt);
      end
      quiet = 1'b0;
   endtask

   initial begin
      int waited;
      for (int k = 0; k <= 256; k++) begin
         sig_points[k] = (k >= 128) ? positive_sigmoid(k - 128)
                                    : 2048 - positive_sigmoid(128 - k);
      end
      unit_loaded = '0;
      failed = 1'b0;
      quiet = 1'b0;
      reset <= 1'b1;
      start <= 1'b0;
      req_func <= FUNC_LOAD;
      req_unit_index <= '0;
      req_xp <= '{default: '0};
      req_hp <= '{default: '0};
      req_cell_prev <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_bias_load_extremes();
      test_gate_saturation();
      test_random_stream(1330);
      start <= 1'b0;
      waited = 0;
      while (pending_cell_results.size() != 0 && waited < 1000) begin
         @(posedge clock);
         waited++;
      end
      repeat (20) @(posedge clock);
      if (!failed && pending_cell_results.size() == 0) begin
         $display("[lstm_cell_forward_pointwise_top] OK");
      end else begin
         if (pending_cell_results.size() != 0) begin
            $error("%0d expected responses never arrived", pending_cell_results.size());
         end
         $display("[lstm_cell_forward_pointwise_top] ERROR");
      end
      $finish;
   end

endmodule
